>>> src/fdec_pkg.sv
package fdec_pkg;

    // pixel word and the size of the reference store
    typedef logic [15:0] t_pix;

    localparam int unsigned STORE_DEPTH = 65536;

    // configuration register indexes
    localparam logic CFG_CODEC_MODE   = 1'b0;
    localparam logic CFG_FRAME_PIXELS = 1'b1;

    // codec modes
    localparam logic MODE_COMPRESS   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

    // read and write requests presented together to the reference store
    typedef struct packed {
        logic  rd_en;
        t_pix  rd_addr;
        logic  wr_en;
        t_pix  wr_addr;
        t_pix  wr_data;
    } t_mem_req;

endpackage

>>> src/frame_delta_escape_codec.sv
// frame_delta_escape_codec
// interframe delta codec with escape records for 16-bit pixels.
// slave channel: one pixel beat per accepted tvalid/tready.
//   tuser marks a raw reference-frame pixel and the escape flag of a coded tuple.
// master channel: one result beat per input beat, tlast on the last pixel of
//   a frame, tuser the escape flag.
// config port: write enable, register index (0 codec mode, 1 frame pixels)
//   and data; write only while no beat is in flight.
// path: an accepted beat passes the middle stage, then the output register, to the master side.
// throughput: one beat per cycle while the master side takes results; each pixel does one
//   read of the reference store when accepted and one write as it leaves the middle stage,
//   and a same-entry overlap is covered by forwarding inside the store.
// reset: position, escape count and config clear at once (mode compress,
//   frame pixels 65536); the reference store is not cleared, so the first
//   frame must be sent as a reference frame.
// stall: a result waits in the output register; the middle stage keeps
//   working and tready drops only when both stages are full.
module frame_delta_escape_codec
    import fdec_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_wdata,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] raw_pixel, [23:16] delta_code, [31:24] high_byte_in
    input  logic [31:0] i_s_axis_tdata,
    // [0] reference_frame, [1] escaped_in
    input  logic [1:0]  i_s_axis_tuser,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] pixel_out, [23:16] code_out, [31:24] high_byte_out,
    // [47:32] pixel_index, [64:48] escape_total, [65] no_gain, [71:66] zero
    output logic [71:0] o_m_axis_tdata,
    // [0] escaped_out
    output logic        o_m_axis_tuser,
    // frame_end
    output logic        o_m_axis_tlast
);

    // frames cannot be longer than the store or than the parameter allows
    localparam int unsigned LIMIT = (MAX_PIXELS < STORE_DEPTH) ? MAX_PIXELS : STORE_DEPTH;
    localparam int unsigned IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam logic [16:0] LIMIT_C = 17'(LIMIT);

    // config registers
    logic        r_mode;
    logic [16:0] r_frame_pixels;

    // frame state
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] n_pos;
    logic [16:0]      r_esc_cnt;
    logic [16:0]      n_esc_cnt;

    // middle stage: item waiting on its reference word
    logic        r_s1_valid;
    logic        r_s1_ref;
    logic        r_s1_esc;
    t_pix        r_s1_raw;
    logic [7:0]  r_s1_code;
    logic [7:0]  r_s1_high;
    t_pix        r_s1_idx;
    logic        r_s1_last;

    // output register
    logic        r_out_valid;
    t_pix        r_out_pix;
    logic [7:0]  r_out_code;
    logic        r_out_esc;
    logic [7:0]  r_out_high;
    t_pix        r_out_idx;
    logic        r_out_last;
    logic [16:0] r_out_total;
    logic        r_out_no_gain;

    logic        in_accept;
    logic        s1_adv;
    logic [16:0] count;
    logic [16:0] pos_next;
    logic        in_last;
    t_mem_req    mem_req;
    t_pix        prev;

    // middle stage results
    t_pix        s1_pix;
    logic [7:0]  s1_code;
    logic        s1_esc;
    logic [7:0]  s1_high;
    logic        s1_count_inc;
    logic [16:0] s1_total;
    logic        s1_no_gain;
    logic [16:0] diff;
    t_pix        delta_ext;

    // effective frame size: zero acts as one, clipped to the store and to MAX_PIXELS
    always_comb begin
        if (r_frame_pixels == 17'd0) begin
            count = 17'd1;
        end else if (r_frame_pixels > LIMIT_C) begin
            count = LIMIT_C;
        end else begin
            count = r_frame_pixels;
        end
    end

    // handshake: middle stage drains into the output register when it is free
    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // frame position advances at accept, it needs no stored data
    assign pos_next = {{(17 - IDX_W){1'b0}}, r_pos} + 17'd1;
    assign in_last  = (pos_next >= count);

    always_comb begin
        n_pos = r_pos;
        if (in_accept) begin
            n_pos = in_last ? '0 : pos_next[IDX_W-1:0];
        end
    end

    // reference store: read at accept, write back as the item leaves
    always_comb begin
        mem_req.rd_en   = in_accept;
        mem_req.rd_addr = 16'(r_pos);
        mem_req.wr_en   = s1_adv;
        mem_req.wr_addr = r_s1_idx;
        mem_req.wr_data = s1_pix;
    end

    fdec_ref_store #(
        .DEPTH (LIMIT)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (prev)
    );

    // pixel coding on the reference word
    assign diff      = {1'b0, r_s1_raw} - {1'b0, prev};
    assign delta_ext = {{8{r_s1_code[7]}}, r_s1_code};

    always_comb begin
        s1_pix       = r_s1_raw;
        s1_code      = 8'd0;
        s1_esc       = 1'b0;
        s1_high      = 8'd0;
        s1_count_inc = 1'b0;
        if (r_s1_ref) begin
            s1_pix = r_s1_raw;
        end else if (r_mode == MODE_COMPRESS) begin
            // out of -128..127 when the bits above the sign bit disagree
            if ((diff[16:7] != 10'h000) && (diff[16:7] != 10'h3ff)) begin
                s1_code      = r_s1_raw[7:0];
                s1_esc       = 1'b1;
                s1_high      = r_s1_raw[15:8];
                s1_count_inc = 1'b1;
            end else begin
                s1_code = diff[7:0];
            end
        end else begin
            s1_esc = r_s1_esc;
            if (r_s1_esc) begin
                s1_pix       = {r_s1_high, r_s1_code};
                s1_count_inc = 1'b1;
            end else begin
                s1_pix = prev + delta_ext;
            end
        end
    end

    assign s1_total   = r_esc_cnt + {16'd0, s1_count_inc};
    assign s1_no_gain = r_s1_last && ({s1_total, 2'b00} > {2'b00, count});

    always_comb begin
        n_esc_cnt = r_esc_cnt;
        if (s1_adv) begin
            n_esc_cnt = r_s1_last ? 17'd0 : s1_total;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_COMPRESS;
            r_frame_pixels <= 17'h10000;
            r_pos          <= '0;
            r_esc_cnt      <= 17'd0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CODEC_MODE:   r_mode         <= i_cfg_wdata[0];
                    CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_wdata;
                    default:          r_mode         <= r_mode;
                endcase
            end
            r_pos     <= n_pos;
            r_esc_cnt <= n_esc_cnt;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ref  <= i_s_axis_tuser[0];
            r_s1_esc  <= i_s_axis_tuser[1];
            r_s1_raw  <= i_s_axis_tdata[15:0];
            r_s1_code <= i_s_axis_tdata[23:16];
            r_s1_high <= i_s_axis_tdata[31:24];
            r_s1_idx  <= 16'(r_pos);
            r_s1_last <= in_last;
        end
        if (s1_adv) begin
            r_out_pix     <= s1_pix;
            r_out_code    <= s1_code;
            r_out_esc     <= s1_esc;
            r_out_high    <= s1_high;
            r_out_idx     <= r_s1_idx;
            r_out_last    <= r_s1_last;
            r_out_total   <= s1_total;
            r_out_no_gain <= s1_no_gain;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_no_gain, r_out_total, r_out_idx,
                              r_out_high, r_out_code, r_out_pix};
    assign o_m_axis_tuser  = r_out_esc;
    assign o_m_axis_tlast  = r_out_last;

    // escape count clears once the last pixel of a frame has left the middle stage
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (r_esc_cnt == 17'd0))
        else $error("escape count not cleared at frame end");

    // no_gain only rides on the last pixel of a frame
    a_no_gain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_no_gain) |-> r_out_last)
        else $error("no_gain outside frame end");

    // an empty middle stage always takes a beat
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_s_axis_tready)
        else $error("input stalled with empty pipeline");

    // a stalled result keeps the middle stage full
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready && r_s1_valid) |=> r_s1_valid)
        else $error("middle stage lost an item under stall");

endmodule

>>> src/fdec_ref_store.sv
module fdec_ref_store
    import fdec_pkg::*;
#(
    parameter int unsigned DEPTH = 65536
) (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_pix     o_rd_data
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_pix             mem [DEPTH];
    t_pix             r_rd_data;
    t_pix             r_fwd_data;
    logic             r_fwd_hit;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_idx = i_req.rd_addr[IDX_W-1:0];
    assign wr_idx = i_req.wr_addr[IDX_W-1:0];

    // read returns the old word; a same-cycle write to that entry is forwarded
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= mem[rd_idx];
            r_fwd_hit  <= i_req.wr_en && (wr_idx == rd_idx);
            r_fwd_data <= i_req.wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule
